[design/psf_pkg.sv]
package psf_pkg;

  // Field and register widths that the pixel format fixes.
  localparam int BYTE_W         = 8;
  localparam int PIXEL_W        = 4 * BYTE_W;
  localparam int CFG_DATA_W     = 10;
  localparam int CFG_ADDR_W     = 1;
  localparam int ROW_WIDTH_RESET = 256;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH   = 1'd1;

  // Filter type codes.
  localparam logic [BYTE_W-1:0] FILTER_SUB = 8'd1;
  localparam logic [BYTE_W-1:0] FILTER_UP  = 8'd2;

  // One input beat.
  typedef struct packed {
    logic [BYTE_W-1:0] red_in;
    logic [BYTE_W-1:0] green_in;
    logic [BYTE_W-1:0] blue_in;
    logic [BYTE_W-1:0] alpha_in;
    logic              last_in_image;
  } px_in_t;

  // One output beat.
  typedef struct packed {
    logic              row_type_valid;
    logic [BYTE_W-1:0] row_type_byte;
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] alpha_out;
    logic              row_end;
    logic              image_end;
  } px_out_t;

  // Per-pixel decisions handed from the row control to the filter pipe.
  typedef struct packed {
    logic              first_col;
    logic              use_sub;
    logic              use_up;
    logic              row_done;
    logic [BYTE_W-1:0] type_byte;
  } row_ctl_t;

endpackage

[design/psf_line_store.sv]
module psf_line_store
  import psf_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic               clk,
  input  logic               en,
  input  logic [AW-1:0]      addr,
  input  logic [PIXEL_W-1:0] wdata,
  output logic [PIXEL_W-1:0] rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  // Read-first port: the old entry is returned while the new pixel replaces it.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

[design/psf_row_ctrl.sv]
module psf_row_ctrl
  import psf_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = 512,
  parameter int CW             = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fire,
  input  logic [PIXEL_W-1:0]    pixel,
  input  logic                  last_in_image,
  output logic [CW-1:0]         column,
  output logic [PIXEL_W-1:0]    left_pixel,
  output row_ctl_t              ctl
);

  localparam int WW = ($clog2(MAX_ROW_PIXELS + 1) > CFG_DATA_W) ?
                      $clog2(MAX_ROW_PIXELS + 1) : CFG_DATA_W;
  localparam int RESET_W = (MAX_ROW_PIXELS < ROW_WIDTH_RESET) ?
                           MAX_ROW_PIXELS : ROW_WIDTH_RESET;

  logic [BYTE_W-1:0] filter_mode;
  logic [CW-1:0]     last_col;
  logic [CW-1:0]     last_col_next;
  logic [WW-1:0]     width_wr;
  logic              first_row;

  // Clamp a written width into 1..MAX_ROW_PIXELS and keep its last column.
  always_comb begin
    width_wr = WW'(cfg_data);
    if (width_wr == '0) begin
      last_col_next = '0;
    end else if (width_wr > WW'(MAX_ROW_PIXELS)) begin
      last_col_next = CW'(MAX_ROW_PIXELS - 1);
    end else begin
      last_col_next = CW'(width_wr - WW'(1));
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= '0;
      last_col    <= CW'(RESET_W - 1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FILTER_MODE: filter_mode <= cfg_data[BYTE_W-1:0];
        REG_ROW_WIDTH:   last_col    <= last_col_next;
        default: ;
      endcase
    end
  end

  // Decisions for the pixel now at the input.
  always_comb begin
    ctl.first_col = (column == '0);
    ctl.use_sub   = (filter_mode == FILTER_SUB) && !ctl.first_col;
    ctl.use_up    = (filter_mode == FILTER_UP) && !first_row;
    ctl.row_done  = last_in_image || (column >= last_col);
    ctl.type_byte = ctl.first_col ? filter_mode : '0;
  end

  // Column counter, first-row flag and left neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      first_row  <= 1'b1;
      left_pixel <= '0;
    end else if (fire) begin
      left_pixel <= pixel;
      if (ctl.row_done) begin
        column    <= '0;
        first_row <= last_in_image;
      end else begin
        column <= column + CW'(1);
      end
    end
  end

endmodule

[design/psf_filter_pipe.sv]
module psf_filter_pipe
  import psf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic               last_in_image,
  input  logic [PIXEL_W-1:0] left_pixel,
  input  row_ctl_t           ctl,
  input  logic [PIXEL_W-1:0] prior_pixel,
  output logic               accept_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output px_out_t            out_data
);

  logic               a_valid;
  logic [PIXEL_W-1:0] a_pixel;
  logic [PIXEL_W-1:0] a_left;
  logic               a_last;
  row_ctl_t           a_ctl;
  logic               b_advance;
  logic [PIXEL_W-1:0] ref_pixel;
  logic [PIXEL_W-1:0] result;

  // Bytewise difference, each lane wrapping modulo 256.
  function automatic logic [PIXEL_W-1:0] sub_bytes(input logic [PIXEL_W-1:0] x,
                                                   input logic [PIXEL_W-1:0] y);
    logic [PIXEL_W-1:0] r;
    for (int k = 0; k < 4; k++) begin
      r[k*BYTE_W +: BYTE_W] = x[k*BYTE_W +: BYTE_W] - y[k*BYTE_W +: BYTE_W];
    end
    return r;
  endfunction

  // Stage A moves on when the output register is empty or being drained.
  assign b_advance = !out_valid || !out_stall;
  assign accept_ok = !a_valid || b_advance;

  // Stage A: the pixel whose line-store entry is being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept_ok) begin
      a_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      a_pixel <= pixel;
      a_left  <= left_pixel;
      a_last  <= last_in_image;
      a_ctl   <= ctl;
    end
  end

  // Filter arithmetic on the stage A pixel.
  always_comb begin
    ref_pixel = a_ctl.use_sub ? a_left : prior_pixel;
    if (a_ctl.use_sub || a_ctl.use_up) begin
      result = sub_bytes(a_pixel, ref_pixel);
    end else begin
      result = a_pixel;
    end
  end

  // Stage B: the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_advance) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance && a_valid) begin
      out_data.row_type_valid <= a_ctl.first_col;
      out_data.row_type_byte  <= a_ctl.type_byte;
      out_data.red_out        <= result[0*BYTE_W +: BYTE_W];
      out_data.green_out      <= result[1*BYTE_W +: BYTE_W];
      out_data.blue_out       <= result[2*BYTE_W +: BYTE_W];
      out_data.alpha_out      <= result[3*BYTE_W +: BYTE_W];
      out_data.row_end        <= a_ctl.row_done;
      out_data.image_end      <= a_last;
    end
  end

endmodule

[design/png_scanline_filter.sv]
// Channel   Direction  Handshake            Beat
// in        input      in_valid / in_stall  one RGBA pixel, px_in_t
// out       output     out_valid/out_stall  one filtered pixel, px_out_t
// cfg       input      cfg_we               one register write, no wait
//
// One pixel is taken per clock while in_stall is low.
// The line store is read and rewritten at the same column on the accepting
// edge, so back-to-back pixels in one column need no forwarding.
// Reset clears counters, flags, valid bits and settings; line store keeps data.
// A stalled output holds one result in the output register and one in stage A;
// the input stalls only when both are full.
module png_scanline_filter
  import psf_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  px_in_t                in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output px_out_t               out_data
);

  localparam int CW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

  logic               accept_ok;
  logic               fire;
  logic [PIXEL_W-1:0] pixel;
  logic [CW-1:0]      column;
  logic [PIXEL_W-1:0] left_pixel;
  logic [PIXEL_W-1:0] prior_pixel;
  row_ctl_t           ctl;

  // Input handshake and pixel word, red in the low byte.
  assign in_stall = !accept_ok;
  assign fire     = in_valid && accept_ok;
  assign pixel    = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};

  psf_row_ctrl #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .CW             (CW)
  ) u_row_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .fire          (fire),
    .pixel         (pixel),
    .last_in_image (in_data.last_in_image),
    .column        (column),
    .left_pixel    (left_pixel),
    .ctl           (ctl)
  );

  psf_line_store #(
    .DEPTH (MAX_ROW_PIXELS),
    .AW    (CW)
  ) u_line_store (
    .clk   (clk),
    .en    (fire),
    .addr  (column),
    .wdata (pixel),
    .rdata (prior_pixel)
  );

  psf_filter_pipe u_filter_pipe (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .pixel         (pixel),
    .last_in_image (in_data.last_in_image),
    .left_pixel    (left_pixel),
    .ctl           (ctl),
    .prior_pixel   (prior_pixel),
    .accept_ok     (accept_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

[bench/png_scanline_filter_tb.sv]
`timescale 1ns / 100ps

module png_scanline_filter_tb
  import psf_pkg::*;
();

  localparam int ROW_PIXELS_MAX = 512;
  localparam int WAIT_MAX       = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  px_in_t                in_data = '0;
  logic                  out_valid;
  logic                  out_stall;
  px_out_t               out_data;

  // Filtered pixels still owed by the block, oldest first.
  px_out_t expected_pixels[$];
  px_out_t want_px;

  // Shadow of the block's filter state and registers.
  logic [31:0]       line_store [0:ROW_PIXELS_MAX-1];
  logic [31:0]       left_px = '0;
  logic [8:0]        next_col = '0;
  logic              in_first_row = 1'b1;
  logic [BYTE_W-1:0] cur_mode = '0;
  logic [9:0]        cur_width = 10'(ROW_WIDTH_RESET);

  // Idling controls shared by the sender, the receiver and the tests.
  logic sender_idle = 1'b1;
  logic receiver_idle = 1'b1;
  logic hold_req = 1'b0;

  int pixels_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  png_scanline_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Width register as the row counter sees it: zero means one, large values clamp.
  function automatic int row_limit(input logic [9:0] w);
    if (w == 0) return 1;
    if (w > ROW_PIXELS_MAX) return ROW_PIXELS_MAX;
    return int'(w);
  endfunction

  // Works out the filtered beat for one accepted pixel and advances the row state.
  function automatic px_out_t filter_pixel(input px_in_t p);
    px_out_t     r;
    logic [31:0] pix;
    logic [31:0] base;
    logic        first_col;
    logic        done;
    pix       = {p.alpha_in, p.blue_in, p.green_in, p.red_in};
    first_col = (next_col == 0);
    base      = '0;
    if (cur_mode == FILTER_SUB && !first_col) begin
      base = left_px;
    end else if (cur_mode == FILTER_UP && !in_first_row) begin
      base = line_store[next_col];
    end
    line_store[next_col] = pix;
    left_px = pix;
    done = p.last_in_image || (int'(next_col) + 1 >= row_limit(cur_width));
    r.row_type_valid = first_col;
    r.row_type_byte  = first_col ? cur_mode : '0;
    r.red_out        = pix[7:0] - base[7:0];
    r.green_out      = pix[15:8] - base[15:8];
    r.blue_out       = pix[23:16] - base[23:16];
    r.alpha_out      = pix[31:24] - base[31:24];
    r.row_end        = done;
    r.image_end      = p.last_in_image;
    if (done) begin
      next_col = '0;
      in_first_row = p.last_in_image;
    end else begin
      next_col = next_col + 1'b1;
    end
    return r;
  endfunction

  function automatic px_in_t mk_px(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] a,
                                   input logic last);
    px_in_t p;
    p.red_in        = r;
    p.green_in      = g;
    p.blue_in       = b;
    p.alpha_in      = a;
    p.last_in_image = last;
    return p;
  endfunction

  // Random byte with the two extremes drawn more often than chance.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic px_in_t rand_pixel(input logic last);
    return mk_px(rand_byte(), rand_byte(), rand_byte(), rand_byte(), last);
  endfunction

  // Offers one pixel and returns right after the edge that accepts it.
  task automatic send_pixel(input px_in_t p);
    int gap;
    gap = sender_idle ? $urandom_range(0, WAIT_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(filter_pixel(p));
    pixels_sent++;
  endtask

  // Stops offering and waits until every owed beat has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    if (addr == REG_FILTER_MODE) begin
      cur_mode = data[BYTE_W-1:0];
    end else begin
      cur_width = data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One full-width row so that every column of the line store holds data.
  task automatic test_fill_line_store();
    write_reg(REG_FILTER_MODE, '0);
    write_reg(REG_ROW_WIDTH, 10'd512);
    for (int i = 0; i < ROW_PIXELS_MAX; i++) begin
      send_pixel(rand_pixel(i == ROW_PIXELS_MAX - 1));
    end
  endtask

  // Sub: first pixel raw, then byte-wise differences that wrap both ways.
  task automatic test_sub_filter();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(FILTER_SUB));
    write_reg(REG_ROW_WIDTH, 10'd3);
    send_pixel(mk_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(mk_px(8'h01, 8'h80, 8'h7F, 8'h00, 1'b0));
    send_pixel(mk_px(8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
    send_pixel(mk_px(8'hFF, 8'h01, 8'hFE, 8'h02, 1'b1));
  endtask

  // Up: first row of each image raw, later rows subtract the row above.
  task automatic test_up_filter();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(FILTER_UP));
    write_reg(REG_ROW_WIDTH, 10'd2);
    send_pixel(mk_px(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
    send_pixel(mk_px(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
    send_pixel(mk_px(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));
    send_pixel(mk_px(8'h13, 8'h33, 8'h57, 8'h77, 1'b1));
    send_pixel(mk_px(8'hAA, 8'hBB, 8'hCC, 8'hDD, 1'b1));
  endtask

  // Unfiltered modes still carry their type byte; upper data bits are ignored.
  task automatic test_other_modes();
    write_reg(REG_FILTER_MODE, 10'h3FF);
    send_pixel(mk_px(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0));
    write_reg(REG_FILTER_MODE, 10'd3);
    send_pixel(mk_px(8'h01, 8'h02, 8'h03, 8'h04, 1'b0));
    write_reg(REG_FILTER_MODE, '0);
    send_pixel(mk_px(8'hFE, 8'hFD, 8'hFC, 8'hFB, 1'b1));
  endtask

  // A zero width acts as one pixel per row; an oversized width clamps.
  task automatic test_width_limits();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(FILTER_SUB));
    write_reg(REG_ROW_WIDTH, 10'd0);
    send_pixel(mk_px(8'h11, 8'h22, 8'h33, 8'h44, 1'b0));
    send_pixel(mk_px(8'h55, 8'h66, 8'h77, 8'h88, 1'b0));
    write_reg(REG_ROW_WIDTH, 10'h3FF);
    send_pixel(mk_px(8'h80, 8'h80, 8'h80, 8'h80, 1'b0));
    send_pixel(mk_px(8'h7F, 8'h81, 8'h00, 8'hFF, 1'b1));
    write_reg(REG_ROW_WIDTH, 10'd1);
    send_pixel(mk_px(8'h09, 8'h08, 8'h07, 8'h06, 1'b1));
  endtask

  // Mode and width change partway through a row.
  task automatic test_mid_row_changes();
    write_reg(REG_ROW_WIDTH, 10'd8);
    send_pixel(mk_px(8'h10, 8'h10, 8'h10, 8'h10, 1'b0));
    send_pixel(mk_px(8'h20, 8'h08, 8'h30, 8'h00, 1'b0));
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(FILTER_UP));
    send_pixel(mk_px(8'h44, 8'h55, 8'h66, 8'h77, 1'b0));
    // Narrowing the row below the current column closes the row at once.
    write_reg(REG_ROW_WIDTH, 10'd2);
    send_pixel(mk_px(8'h01, 8'hF0, 8'h0F, 8'hEE, 1'b0));
    send_pixel(mk_px(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
    send_pixel(mk_px(8'hC0, 8'h03, 8'h99, 8'h66, 1'b1));
  endtask

  // An image that ends partway through a row; the next pixel opens a new image.
  task automatic test_image_end_mid_row();
    write_reg(REG_ROW_WIDTH, 10'd5);
    send_pixel(mk_px(8'h31, 8'h32, 8'h33, 8'h34, 1'b0));
    send_pixel(mk_px(8'h41, 8'h42, 8'h43, 8'h44, 1'b1));
    send_pixel(mk_px(8'h51, 8'h52, 8'h53, 8'h54, 1'b1));
  endtask

  // The output holds off for a long stretch while pixels keep coming.
  task automatic test_output_backpressure();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(FILTER_SUB));
    write_reg(REG_ROW_WIDTH, 10'd16);
    sender_idle = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_pixel(rand_pixel(i == 39));
    end
    sender_idle = 1'b1;
  endtask

  // Random phases: new settings, then mostly whole images with random content.
  task automatic test_random_streams();
    logic [BYTE_W-1:0] mode_sel;
    logic [9:0]        width_sel;
    int                rows_left;
    int                pick;
    logic              last;
    for (int ph = 0; ph < 20; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) mode_sel = FILTER_SUB;
      else if (pick < 8) mode_sel = FILTER_UP;
      else if (pick == 8) mode_sel = '0;
      else mode_sel = 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 14) width_sel = 10'($urandom_range(1, 8));
      else if (pick < 17) width_sel = 10'($urandom_range(9, 40));
      else if (pick == 17) width_sel = '0;
      else if (pick == 18) width_sel = 10'd512;
      else width_sel = 10'($urandom_range(513, 1023));
      write_reg(REG_FILTER_MODE, {2'($urandom), mode_sel});
      write_reg(REG_ROW_WIDTH, width_sel);
      sender_idle   = ($urandom_range(0, 2) != 0);
      receiver_idle = ($urandom_range(0, 2) != 0);
      rows_left = $urandom_range(1, 4);
      repeat ($urandom_range(30, 80)) begin
        if (int'(next_col) + 1 >= row_limit(cur_width)) begin
          last = (rows_left <= 1);
          rows_left = last ? $urandom_range(1, 4) : rows_left - 1;
        end else begin
          // Now and then an image is cut short in the middle of a row.
          last = ($urandom_range(0, 39) == 0);
          if (last) rows_left = $urandom_range(1, 4);
        end
        send_pixel(rand_pixel(last));
      end
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Receiver: waits a drawn number of cycles before taking each result beat.
  initial begin : result_receiver
    int   wait_cycles;
    logic hold_taken;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        wait_cycles = HOLD_CYCLES;
        hold_taken = 1'b1;
      end else begin
        wait_cycles = receiver_idle ? $urandom_range(0, WAIT_MAX) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Each accepted result beat is compared with the oldest owed pixel.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: %h", out_data);
        end
      end else begin
        want_px = expected_pixels.pop_front();
        results_checked++;
        if (out_data.row_type_valid !== want_px.row_type_valid ||
            out_data.row_type_byte !== want_px.row_type_byte ||
            out_data.red_out !== want_px.red_out ||
            out_data.green_out !== want_px.green_out ||
            out_data.blue_out !== want_px.blue_out ||
            out_data.alpha_out !== want_px.alpha_out ||
            out_data.row_end !== want_px.row_end ||
            out_data.image_end !== want_px.image_end) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d expected: type %b/%h rgba %h %h %h %h row_end %b image_end %b",
                     results_checked, want_px.row_type_valid, want_px.row_type_byte,
                     want_px.red_out, want_px.green_out, want_px.blue_out,
                     want_px.alpha_out, want_px.row_end, want_px.image_end);
            $display("result %0d actual:   type %b/%h rgba %h %h %h %h row_end %b image_end %b",
                     results_checked, out_data.row_type_valid, out_data.row_type_byte,
                     out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.alpha_out, out_data.row_end, out_data.image_end);
          end
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("png_scanline_filter_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_fill_line_store();
    test_sub_filter();
    test_up_filter();
    test_other_modes();
    test_width_limits();
    test_mid_row_changes();
    test_image_end_mid_row();
    test_output_backpressure();
    test_random_streams();
    drain_results();
    repeat (8) @(negedge clk);
    $display("summary: %0d pixels sent through Sub, Up and unfiltered modes, %0d results checked",
             pixels_sent, results_checked);
    $display("summary: widths zero to oversized, mid-row changes, long output hold, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("png_scanline_filter_tb: clean");
    end else begin
      $display("png_scanline_filter_tb: errors");
    end
    $finish;
  end

endmodule
